// ----- src/skrt_pkg.sv -----
// ----------------------------------------------------------------------------
// skrt_pkg: shared types and codes of the sorted key record table
// Field widths, operation and status codes, sequencer state type.
// ----------------------------------------------------------------------------
package skrt_pkg;

	// fixed field widths of the word ports
	localparam int MODE_W  = 2;
	localparam int KEY_W   = 16;
	localparam int CNT_W   = 8;
	localparam int SIZE_W  = 16;
	localparam int POS_W   = 4;
	localparam int STAT_W  = 2;
	localparam int OCC_W   = 5;

	// default sizing
	localparam int DEF_CAPACITY = 16;
	localparam int DEF_KEY_BITS = 16;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_DUP   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_RDWAIT,
		ST_RESP
	} state_t;

endpackage

// ----- src/skrt_ram.sv -----
// ----------------------------------------------------------------------------
// skrt_ram: generic simple dual port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module skrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/sorted_key_record_table_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_key_record_table_unit: sorted record table with insert and lookup
// Keeps up to CAPACITY records (key, count, size) in ascending key order in
// one ram; a small sequencer scans, shifts and reads it one entry a cycle.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              word fields
//  --------  ---------  ---------------------  ----------------------------------
//  in        to block   in_valid / in_stall    mode key payload_count payload_size
//                                              position
//  out       from block out_valid / out_stall  status found key_out count_out
//                                              size_out occupancy
//
//  sequence: take the word, scan, shift, answer; the ram read port walks one
//  entry a cycle. scan: upward to the first key not below the probe, or past
//  all n keys, ending at once when empty; insert shift: downward from the top
//  to the gap, only the new record when appending. read waits for the ram word.
//  reset: only the record count and control clear; the ram needs no sweep.
//  stalls: in_stall is high while busy; a stalled result holds the output register
//
module sorted_key_record_table_unit
	import skrt_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int KEY_BITS = DEF_KEY_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	// input word channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [MODE_W-1:0] mode,
	input  logic [KEY_W-1:0]  key,
	input  logic [CNT_W-1:0]  payload_count,
	input  logic [SIZE_W-1:0] payload_size,
	input  logic [POS_W-1:0]  position,
	// result word channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [STAT_W-1:0] status,
	output logic              found,
	output logic [KEY_W-1:0]  key_out,
	output logic [CNT_W-1:0]  count_out,
	output logic [SIZE_W-1:0] size_out,
	output logic [OCC_W-1:0]  occupancy
);

	// stored key width: only the low KEY_BITS of the key port take part
	localparam int KW   = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int RW   = KW + CNT_W + SIZE_W;
	localparam int IW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	state_t state_q, state_d;

	// control registers
	logic [CW-1:0]     held_q;
	logic              vld_s1;
	logic              out_valid_q;

	// operation registers
	logic [MODE_W-1:0] mode_q;
	logic [KW-1:0]     k_q;
	logic [CNT_W-1:0]  pc_q;
	logic [SIZE_W-1:0] ps_q;
	logic [CW-1:0]     ptr_q;
	logic [CW-1:0]     idx_s1;
	logic [CW-1:0]     at_q;
	logic [CW-1:0]     rem_q;

	// pending result, moved to the output register when it is free
	logic [STAT_W-1:0] res_status_q;
	logic              res_found_q;
	logic [KW-1:0]     res_key_q;
	logic [CNT_W-1:0]  res_cnt_q;
	logic [SIZE_W-1:0] res_size_q;

	// output register
	logic [STAT_W-1:0] status_q;
	logic              found_q;
	logic [KEY_W-1:0]  key_out_q;
	logic [CNT_W-1:0]  count_out_q;
	logic [SIZE_W-1:0] size_out_q;
	logic [OCC_W-1:0]  occupancy_q;

	// ram port
	logic              ram_we;
	logic [IW-1:0]     ram_waddr;
	logic [RW-1:0]     ram_wdata;
	logic [IW-1:0]     ram_raddr;
	logic [RW-1:0]     ram_rdata;

	logic [KW-1:0]     rd_key;
	logic [CNT_W-1:0]  rd_cnt;
	logic [SIZE_W-1:0] rd_size;

	logic              rd_issue;
	logic              in_take;
	logic              out_free;
	logic              full;
	logic              pos_bad;
	logic [CW-1:0]     nxt_idx;
	logic              hit_ge;
	logic              scan_last;
	logic              scan_done;
	logic              scan_found;
	logic [CW-1:0]     scan_at;
	logic              shift_done;

	skrt_ram #(
		.WIDTH (RW),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// record layout in the ram: {key, count, size}
	assign rd_key  = ram_rdata[RW-1 -: KW];
	assign rd_cnt  = ram_rdata[SIZE_W +: CNT_W];
	assign rd_size = ram_rdata[SIZE_W-1:0];

	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign full     = (held_q == CW'(CAPACITY));
	assign pos_bad  = (CMPW'(position) >= CMPW'(held_q));
	assign nxt_idx  = idx_s1 + CW'(1);

	// scan compare on the word read in the previous cycle
	assign hit_ge     = vld_s1 && (rd_key >= k_q);
	assign scan_last  = vld_s1 && (nxt_idx == held_q);
	assign scan_done  = (held_q == '0) || hit_ge || scan_last;
	assign scan_found = hit_ge && (rd_key == k_q);
	assign scan_at    = hit_ge ? idx_s1 : held_q;

	// shifting is over when no read is left and the last move is written
	assign shift_done = (rem_q == '0) && !vld_s1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					case (mode)
						MODE_INSERT, MODE_LOOKUP: state_d = ST_SCAN;
						MODE_READ:                state_d = pos_bad ? ST_RESP : ST_RDWAIT;
						default:                  state_d = ST_RESP;
					endcase
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					if (mode_q == MODE_INSERT && !scan_found && !full) begin
						state_d = ST_SHIFT;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_SHIFT: begin
				if (shift_done) begin
					state_d = ST_RESP;
				end
			end
			ST_RDWAIT: state_d = ST_RESP;
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: handshake and ram port
	always_comb begin
		in_stall  = 1'b1;
		rd_issue  = 1'b0;
		ram_raddr = IW'(position);
		ram_we    = 1'b0;
		ram_waddr = at_q[IW-1:0];
		ram_wdata = ram_rdata;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_SCAN: begin
				// walk upward from rank 0
				rd_issue  = (ptr_q < held_q);
				ram_raddr = ptr_q[IW-1:0];
			end
			ST_SHIFT: begin
				// walk downward, each record moves one place up
				rd_issue  = (rem_q != '0);
				ram_raddr = ptr_q[IW-1:0];
				if (vld_s1) begin
					ram_we    = 1'b1;
					ram_waddr = nxt_idx[IW-1:0];
				end else if (!rd_issue) begin
					// gap is open, drop the new record in
					ram_we    = 1'b1;
					ram_wdata = {k_q, pc_q, ps_q};
				end
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			held_q      <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_issue && (state_d == state_q);
			if (state_q == ST_SHIFT && shift_done) begin
				held_q <= held_q + CW'(1);
			end
			if (state_q == ST_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// operation and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					mode_q       <= mode;
					k_q          <= key[KW-1:0];
					pc_q         <= payload_count;
					ps_q         <= payload_size;
					ptr_q        <= '0;
					res_status_q <= (mode == MODE_READ && pos_bad) ? STAT_RANGE : STAT_DONE;
					res_found_q  <= 1'b0;
					res_key_q    <= '0;
					res_cnt_q    <= '0;
					res_size_q   <= '0;
				end
			end
			ST_SCAN: begin
				idx_s1 <= ptr_q;
				if (scan_done) begin
					at_q        <= scan_at;
					ptr_q       <= held_q - CW'(1);
					rem_q       <= held_q - scan_at;
					res_found_q <= scan_found;
					// a lookup hit is plain success, only an insert is refused
					if (mode_q == MODE_INSERT && scan_found) begin
						res_status_q <= STAT_DUP;
					end else if (mode_q == MODE_INSERT && full) begin
						res_status_q <= STAT_FULL;
					end else begin
						res_status_q <= STAT_DONE;
					end
				end else if (rd_issue) begin
					ptr_q <= ptr_q + CW'(1);
				end
			end
			ST_SHIFT: begin
				idx_s1 <= ptr_q;
				if (rd_issue) begin
					ptr_q <= ptr_q - CW'(1);
					rem_q <= rem_q - CW'(1);
				end
			end
			ST_RDWAIT: begin
				res_key_q  <= rd_key;
				res_cnt_q  <= rd_cnt;
				res_size_q <= rd_size;
			end
			ST_RESP: begin
				if (out_free) begin
					status_q    <= res_status_q;
					found_q     <= res_found_q;
					key_out_q   <= KEY_W'(res_key_q);
					count_out_q <= res_cnt_q;
					size_out_q  <= res_size_q;
					occupancy_q <= OCC_W'(held_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign found     = found_q;
	assign key_out   = key_out_q;
	assign count_out = count_out_q;
	assign size_out  = size_out_q;
	assign occupancy = occupancy_q;

`ifndef ASSERT_OFF
	// record count never passes the table size
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(CAPACITY))
		else $error("record count beyond capacity");

	// record count only ever grows by one, at the end of a shift
	a_held_step: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q != $past(held_q)) |->
			(held_q == $past(held_q) + CW'(1)) && ($past(state_q) == ST_SHIFT))
		else $error("record count changed outside an insert");

	// a new result word only comes from the response state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_RESP))
		else $error("result word raised outside response state");

	// ram writes happen only while shifting, and never go above the count
	a_ram_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_SHIFT) && (CW'(ram_waddr) <= held_q))
		else $error("ram write outside the shift window");
`endif

endmodule

// ----- test/skrt_table_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// skrt_table_checker: scoreboard of the sorted key record table
// Mirrors the table on every accepted operation and compares result words.
// ----------------------------------------------------------------------------
module skrt_table_checker
	import skrt_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int KEY_BITS = DEF_KEY_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [MODE_W-1:0] mode,
	input  logic [KEY_W-1:0]  key,
	input  logic [CNT_W-1:0]  payload_count,
	input  logic [SIZE_W-1:0] payload_size,
	input  logic [POS_W-1:0]  position,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [STAT_W-1:0] status,
	input  logic              found,
	input  logic [KEY_W-1:0]  key_out,
	input  logic [CNT_W-1:0]  count_out,
	input  logic [SIZE_W-1:0] size_out,
	input  logic [OCC_W-1:0]  occupancy,
	output int                fail_count,
	output int                pending,
	output int                words_seen,
	output int                dup_refusals,
	output int                full_refusals,
	output int                range_reads,
	output int                found_hits
);

	localparam logic [KEY_W-1:0] KEY_MASK =
		(KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} : KEY_W'((1 << KEY_BITS) - 1);

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              found;
		logic [KEY_W-1:0]  key;
		logic [CNT_W-1:0]  cnt;
		logic [SIZE_W-1:0] size;
		logic [OCC_W-1:0]  occ;
	} table_result_t;

	// mirrored table contents, kept in ascending key order
	logic [KEY_W-1:0]  tbl_key  [CAPACITY];
	logic [CNT_W-1:0]  tbl_cnt  [CAPACITY];
	logic [SIZE_W-1:0] tbl_size [CAPACITY];
	int                held = 0;

	table_result_t     result_q [$];
	table_result_t     got;
	table_result_t     want;

	assign pending = result_q.size();

	// apply one operation to the mirror and return the result it should give
	task automatic apply_op(
		input  logic [MODE_W-1:0] op,
		input  logic [KEY_W-1:0]  k_in,
		input  logic [CNT_W-1:0]  c_in,
		input  logic [SIZE_W-1:0] s_in,
		input  logic [POS_W-1:0]  p_in,
		output table_result_t     r
	);
		logic [KEY_W-1:0] k;
		int               rank;
		bit               present;
		r = '0;
		r.status = STAT_DONE;
		k = k_in & KEY_MASK;
		rank = 0;
		while (rank < held && tbl_key[rank] < k)
			rank++;
		present = (rank < held) && (tbl_key[rank] == k);
		case (op)
			MODE_INSERT: begin
				if (present) begin
					r.status = STAT_DUP;
					r.found  = 1'b1;
				end else if (held >= CAPACITY) begin
					r.status = STAT_FULL;
				end else begin
					for (int j = held; j > rank; j--) begin
						tbl_key[j]  = tbl_key[j-1];
						tbl_cnt[j]  = tbl_cnt[j-1];
						tbl_size[j] = tbl_size[j-1];
					end
					tbl_key[rank]  = k;
					tbl_cnt[rank]  = c_in;
					tbl_size[rank] = s_in;
					held++;
				end
			end
			MODE_LOOKUP: r.found = present;
			MODE_READ: begin
				if (int'(p_in) >= held) begin
					r.status = STAT_RANGE;
				end else begin
					r.key  = tbl_key[p_in];
					r.cnt  = tbl_cnt[p_in];
					r.size = tbl_size[p_in];
				end
			end
			default: ;
		endcase
		r.occ = OCC_W'(held);
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v, got_v);
		if (exp_v !== got_v) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held          = 0;
			fail_count    = 0;
			words_seen    = 0;
			dup_refusals  = 0;
			full_refusals = 0;
			range_reads   = 0;
			found_hits    = 0;
			result_q.delete();
		end else begin
			// result side first: a word leaving now belongs to an older operation
			if (out_valid && !out_stall) begin
				got = '{status, found, key_out, count_out, size_out, occupancy};
				if (result_q.size() == 0) begin
					$error("result word with no operation outstanding");
					fail_count++;
				end else begin
					want = result_q.pop_front();
					check_field("status", want.status, got.status);
					check_field("found", want.found, got.found);
					check_field("key_out", want.key, got.key);
					check_field("count_out", want.cnt, got.cnt);
					check_field("size_out", want.size, got.size);
					check_field("occupancy", want.occ, got.occ);
				end
			end
			if (in_valid && !in_stall) begin
				apply_op(mode, key, payload_count, payload_size, position, want);
				result_q.push_back(want);
				words_seen++;
				if (mode == MODE_INSERT && want.status == STAT_DUP)
					dup_refusals++;
				if (want.status == STAT_FULL)
					full_refusals++;
				if (want.status == STAT_RANGE)
					range_reads++;
				if (mode == MODE_LOOKUP && want.found)
					found_hits++;
			end
		end
	end

endmodule

// ----- test/tb_sorted_key_record_table_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_key_record_table_unit: testbench of the sorted record table
// Drives directed and random insert, lookup, read and unused-mode words with random gaps
// and result stalls; a checker beside the block mirrors the table.
// ----------------------------------------------------------------------------
module tb_sorted_key_record_table_unit;
	import skrt_pkg::*;

	// the mode code the block leaves unused; it must pass through untouched
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	// random words after the directed part
	localparam int RANDOM_WORDS = 800;
	// idle cycles without any handshake before the run is declared hung;
	// well above the slowest operation plus the longest result stall and input gap
	localparam int HANG_LIMIT = 2000;
	// settle time after the last result
	localparam int DRAIN_CYCLES = 40;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [MODE_W-1:0] mode;
	logic [KEY_W-1:0]  key;
	logic [CNT_W-1:0]  payload_count;
	logic [SIZE_W-1:0] payload_size;
	logic [POS_W-1:0]  position;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [STAT_W-1:0] status;
	logic              found;
	logic [KEY_W-1:0]  key_out;
	logic [CNT_W-1:0]  count_out;
	logic [SIZE_W-1:0] size_out;
	logic [OCC_W-1:0]  occupancy;

	int fail_count;
	int pending;
	int words_seen;
	int dup_refusals;
	int full_refusals;
	int range_reads;
	int found_hits;

	// recent keys sent, reused to hit duplicates and successful lookups
	logic [KEY_W-1:0] key_hist [$];

	int idle_cycles = 0;
	int stall_run = 0;
	int stall_pick;

	sorted_key_record_table_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.key           (key),
		.payload_count (payload_count),
		.payload_size  (payload_size),
		.position      (position),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.found         (found),
		.key_out       (key_out),
		.count_out     (count_out),
		.size_out      (size_out),
		.occupancy     (occupancy)
	);

	skrt_table_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.key           (key),
		.payload_count (payload_count),
		.payload_size  (payload_size),
		.position      (position),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.found         (found),
		.key_out       (key_out),
		.count_out     (count_out),
		.size_out      (size_out),
		.occupancy     (occupancy),
		.fail_count    (fail_count),
		.pending       (pending),
		.words_seen    (words_seen),
		.dup_refusals  (dup_refusals),
		.full_refusals (full_refusals),
		.range_reads   (range_reads),
		.found_hits    (found_hits)
	);

	// 2 ns clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// result side back-pressure: runs of no stall, short stalls, rare long ones
	always @(posedge clk) begin
		if (stall_run > 0) begin
			stall_run <= stall_run - 1;
		end else begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 50) begin
				out_stall <= 1'b0;
				stall_run <= $urandom_range(0, 30);
			end else if (stall_pick < 85) begin
				out_stall <= 1'b1;
				stall_run <= $urandom_range(0, 2);
			end else if (stall_pick < 97) begin
				out_stall <= 1'b1;
				stall_run <= $urandom_range(3, 10);
			end else begin
				out_stall <= 1'b1;
				stall_run <= $urandom_range(20, 60);
			end
		end
	end

	// hang detection: counts cycles in which neither channel moves a word
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("no handshake for %0d cycles, %0d results outstanding",
					HANG_LIMIT, pending);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// send one word: optional gap first, then hold it until the block takes it
	task automatic issue_word(
		input logic [MODE_W-1:0] op,
		input logic [KEY_W-1:0]  k,
		input logic [CNT_W-1:0]  c,
		input logic [SIZE_W-1:0] s,
		input logic [POS_W-1:0]  p
	);
		int roll;
		int gap;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			gap = 0;
		else if (roll < 90)
			gap = $urandom_range(1, 3);
		else if (roll < 98)
			gap = $urandom_range(4, 10);
		else
			gap = $urandom_range(20, 50);
		// valid only drops when a gap follows, so it never toggles within a step
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		mode          <= op;
		key           <= k;
		payload_count <= c;
		payload_size  <= s;
		position      <= p;
		do @(posedge clk); while (in_stall);
		if (op == MODE_INSERT || op == MODE_LOOKUP) begin
			key_hist.push_back(k);
			if (key_hist.size() > 48)
				void'(key_hist.pop_front());
		end
	endtask

	initial begin
		int               roll;
		logic [MODE_W-1:0] op;
		logic [KEY_W-1:0]  k;

		// every input known from time zero
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		mode          = MODE_INSERT;
		key           = '0;
		payload_count = '0;
		payload_size  = '0;
		position      = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty table, key and payload extremes, ordering at both ends
		issue_word(MODE_READ,   16'h0000, 8'h00, 16'h0000, 4'd0);   // read of empty table
		issue_word(MODE_READ,   16'hffff, 8'hff, 16'hffff, 4'd15);
		issue_word(MODE_LOOKUP, 16'h0000, 8'h00, 16'h0000, 4'd0);   // lookup misses when empty
		issue_word(MODE_UNUSED, 16'hffff, 8'hff, 16'hffff, 4'd15);  // unused mode is a no-op
		issue_word(MODE_INSERT, 16'h8000, 8'h00, 16'h0000, 4'd0);
		issue_word(MODE_INSERT, 16'h0000, 8'hff, 16'hffff, 4'd0);   // new smallest key
		issue_word(MODE_INSERT, 16'hffff, 8'h5a, 16'ha5a5, 4'd15);  // new largest key
		issue_word(MODE_INSERT, 16'h8000, 8'h11, 16'h2222, 4'd0);   // duplicate refused
		issue_word(MODE_LOOKUP, 16'hffff, 8'h00, 16'h0000, 4'd0);
		issue_word(MODE_LOOKUP, 16'h7fff, 8'h00, 16'h0000, 4'd0);
		issue_word(MODE_READ,   16'h0000, 8'h00, 16'h0000, 4'd0);
		issue_word(MODE_READ,   16'h0000, 8'h00, 16'h0000, 4'd1);
		issue_word(MODE_READ,   16'h0000, 8'h00, 16'h0000, 4'd2);
		issue_word(MODE_READ,   16'h0000, 8'h00, 16'h0000, 4'd3);   // rank equal to count
		issue_word(MODE_READ,   16'h0000, 8'h00, 16'h0000, 4'd15);
		issue_word(MODE_INSERT, 16'h0001, 8'h80, 16'h8000, 4'd7);   // shifts the upper records
		issue_word(MODE_READ,   16'h0000, 8'h00, 16'h0000, 4'd1);
		issue_word(MODE_UNUSED, 16'h0000, 8'h00, 16'h0000, 4'd0);
		issue_word(MODE_INSERT, 16'h0000, 8'h01, 16'h0001, 4'd0);   // duplicate at rank zero

		// random: table fills early and then stays full, so refusals on a full
		// table, duplicates and reads of every rank all get plenty of hits
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 30)
				op = MODE_INSERT;
			else if (roll < 55)
				op = MODE_LOOKUP;
			else if (roll < 92)
				op = MODE_READ;
			else
				op = MODE_UNUSED;
			roll = $urandom_range(0, 99);
			if (roll < 40 && key_hist.size() > 0)
				k = key_hist[$urandom_range(0, key_hist.size() - 1)];
			else if (roll < 50 && key_hist.size() > 0)
				// neighbors of known keys probe the ordering edges
				k = key_hist[$urandom_range(0, key_hist.size() - 1)]
					+ ($urandom_range(0, 1) ? 16'h0001 : 16'hffff);
			else
				k = KEY_W'($urandom());
			issue_word(op, k, CNT_W'($urandom()), SIZE_W'($urandom()),
				POS_W'($urandom_range(0, 15)));
		end
		in_valid <= 1'b0;

		// drain every outstanding result, then let the block settle
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("checked %0d words: %0d duplicate inserts, %0d inserts into a full table",
			words_seen, dup_refusals, full_refusals);
		$display("%0d reads past the record count, %0d lookups that hit",
			range_reads, found_hits);
		if (fail_count == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
